// ===== hw/rtl/ssdp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssdp_pkg
// Shared types and codes for the security serial data port.
// ----------------------------------------------------------------------------
`default_nettype none

package ssdp_pkg;

  localparam int KeyW     = 64;
  localparam int CfgIdxW  = 1;
  localparam int OpcodeW  = 3;

  // Access codes
  localparam logic [OpcodeW-1:0] OpDataRead  = 3'd0;
  localparam logic [OpcodeW-1:0] OpByteWrite = 3'd1;
  localparam logic [OpcodeW-1:0] OpNibLatch  = 3'd2;
  localparam logic [OpcodeW-1:0] OpStrobe    = 3'd3;
  localparam logic [OpcodeW-1:0] OpCtrlWrite = 3'd4;
  localparam logic [OpcodeW-1:0] OpStatRead  = 3'd5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgKeyLow  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgKeyHigh = 1'b1;

  // Control word bits
  localparam int CtrlSoundRstBit = 4;
  localparam int CtrlChipRstBit  = 5;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [15:0]        write_data;
    logic [1:0]         byte_enables;
  } ssdp_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       status_flag;
    logic       sound_reset;
  } ssdp_out_t;

endpackage : ssdp_pkg

`default_nettype wire

// ===== hw/rtl/security_serial_data_port_unit.sv =====
// ----------------------------------------------------------------------------
// security_serial_data_port_unit
// Serial key port of a protection chip: hands out 16 key bytes one per strobe.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one bus access per transaction (opcode, write data, byte lanes).
//   out_*  : one result per access: read data, status bit after the access,
//            sound reset line (bit 4 of the control word).
//   cfg_*  : key byte registers, index 0 = bytes 0..7, index 1 = bytes 8..15.
//            Write only with no access in flight (unenforced); always ready.
// Path: an accepted access lands in the input register, then its result is
//   registered in the result register and shown on out_*.
// Throughput: one access per cycle unless out_ready stalls; the two register
//   stages both advance when the result register is empty or being taken.
// Stall: when out_ready is low the result holds, the input register fills,
//   and in_ready drops once both are full.
// Reset (rst_n low, synchronous): pipeline empty, key registers, buffer,
//   key index, status, latched nibble and control word all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module security_serial_data_port_unit
  import ssdp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // access channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ssdp_in_t           in_data,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ssdp_out_t               out_data,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [KeyW-1:0]    cfg_data
);

  logic [KeyW-1:0] key_lo_r, key_hi_r;
  logic [7:0]      buf_r, buf_nxt;
  logic [3:0]      idx_r, idx_nxt;
  logic            stat_r, stat_nxt;
  logic [3:0]      nib_r, nib_nxt;
  logic [15:0]     ctrl_r, ctrl_nxt;

  logic            s1_v_r;
  ssdp_in_t        s1_r;
  logic            out_v_r;
  ssdp_out_t       out_r, out_nxt;
  logic            s1_adv;

  logic [127:0]    keys;
  logic [7:0]      key_byte;
  logic [7:0]      wr_byte;
  logic            do_wr;
  logic [15:0]     lane_mask;
  logic            low_lane;

  assign s1_adv    = s1_v_r && (!out_v_r || out_ready);
  assign in_ready  = !s1_v_r || s1_adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  assign keys     = {key_hi_r, key_lo_r};
  assign key_byte = keys[{idx_r, 3'b000} +: 8];
  assign low_lane = s1_r.byte_enables[0];
  assign lane_mask = {{8{s1_r.byte_enables[1]}}, {8{s1_r.byte_enables[0]}}};

  always_comb begin
    buf_nxt  = buf_r;
    idx_nxt  = idx_r;
    stat_nxt = stat_r;
    nib_nxt  = nib_r;
    ctrl_nxt = ctrl_r;
    do_wr    = 1'b0;
    wr_byte  = s1_r.write_data[7:0];
    out_nxt.read_data = 8'd0;

    case (s1_r.opcode)
      OpDataRead: begin
        out_nxt.read_data = buf_r;
        stat_nxt = 1'b1;
      end
      OpByteWrite: begin
        do_wr = low_lane;
      end
      OpNibLatch: begin
        if (low_lane) nib_nxt = s1_r.write_data[3:0];
      end
      OpStrobe: begin
        do_wr   = low_lane;
        wr_byte = {3'b000, ~s1_r.write_data[1], nib_r};
      end
      OpCtrlWrite: begin
        ctrl_nxt = (ctrl_r & ~lane_mask) | (s1_r.write_data & lane_mask);
        // chip reset on rising bit 5
        if (!ctrl_r[CtrlChipRstBit] && ctrl_nxt[CtrlChipRstBit]) begin
          idx_nxt  = 4'd0;
          stat_nxt = 1'b0;
          buf_nxt  = 8'd0;
        end
      end
      OpStatRead: begin
        out_nxt.read_data = {6'd0, stat_r, 1'b1};
      end
      default: begin
      end
    endcase

    if (do_wr) begin
      stat_nxt = wr_byte[4];
      if (!wr_byte[4]) begin
        if (wr_byte[3:0] != 4'd0) begin
          buf_nxt = wr_byte;
        end else begin
          buf_nxt = key_byte;
          idx_nxt = idx_r + 4'd1;
        end
      end
    end

    out_nxt.status_flag = stat_nxt;
    out_nxt.sound_reset = ctrl_nxt[CtrlSoundRstBit];
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      key_lo_r <= '0;
      key_hi_r <= '0;
      buf_r    <= '0;
      idx_r    <= '0;
      stat_r   <= 1'b0;
      nib_r    <= '0;
      ctrl_r   <= '0;
    end else begin
      if (in_ready) s1_v_r <= in_valid;
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgKeyLow:  key_lo_r <= cfg_data;
          CfgKeyHigh: key_hi_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (s1_adv) begin
        buf_r  <= buf_nxt;
        idx_r  <= idx_nxt;
        stat_r <= stat_nxt;
        nib_r  <= nib_nxt;
        ctrl_r <= ctrl_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_r <= in_data;
    if (s1_adv) out_r <= out_nxt;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_v_r)
    else $error("accepted access did not reach input register");

  a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_ready) |=> (s1_v_r && $stable(s1_r)))
    else $error("input register changed while result stalled");

  a_data_read_sets_status: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_r.opcode == OpDataRead) |=> (out_v_r && out_r.status_flag))
    else $error("data read did not set status");

  a_status_read_format: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_r.opcode == OpStatRead) |=>
      (out_r.read_data[0] && out_r.read_data[7:2] == 6'd0 &&
       out_r.read_data[1] == out_r.status_flag))
    else $error("status read data malformed");

endmodule : security_serial_data_port_unit

`default_nettype wire
